// ===== rtl/core/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants for the 64-bit modular exponentiation unit.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int unsigned FIELD_BITS = 64;

    typedef logic [FIELD_BITS-1:0] t_word;

    // Control from sequencer to modular multiplier.
    typedef struct packed {
        logic start;
    } t_mul_ctrl;

    // Status from modular multiplier back to sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

// ===== rtl/core/modexp_if.sv =====
// ----------------------------------------------------------------------------
// modexp_in_if / modexp_out_if
// Valid/ready channels carrying the operand and result items.
// ----------------------------------------------------------------------------
interface modexp_in_if;
    logic                 valid;
    logic                 ready;
    modexp_pkg::t_word    base_value;
    modexp_pkg::t_word    exponent_value;
    modexp_pkg::t_word    modulus_value;

    modport source (output valid, output base_value, output exponent_value,
                    output modulus_value, input ready);
    modport sink   (input valid, input base_value, input exponent_value,
                    input modulus_value, output ready);
endinterface

interface modexp_out_if;
    logic                 valid;
    logic                 ready;
    modexp_pkg::t_word    power_result;
    logic                 bad_modulus;

    modport source (output valid, output power_result, output bad_modulus,
                    input ready);
    modport sink   (input valid, input power_result, input bad_modulus,
                    output ready);
endinterface

// ===== rtl/core/modexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// modexp_mulmod
// Iterative (x * y) mod m, MSB-first interleaved shift-and-add, one bit/cycle.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
    parameter int unsigned OPERAND_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  modexp_pkg::t_mul_ctrl         i_ctrl,
    input  logic [OPERAND_BITS-1:0]       i_x,
    input  logic [OPERAND_BITS-1:0]       i_y,
    input  logic [OPERAND_BITS-1:0]       i_m,
    output modexp_pkg::t_mul_stat         o_stat,
    output logic [OPERAND_BITS-1:0]       o_product
);
    import modexp_pkg::*;

    localparam int unsigned CW = $clog2(OPERAND_BITS);

    logic [OPERAND_BITS-1:0] r_acc, n_acc;
    logic [OPERAND_BITS-1:0] r_y, n_y;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [OPERAND_BITS:0]   dbl, dbl_red, sum, sum_red;
    logic [OPERAND_BITS-1:0] acc_dbl;

    // x is always below m here (sequencer keeps operands reduced).
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_m}) ? dbl - {1'b0, i_m} : dbl;
        acc_dbl = dbl_red[OPERAND_BITS-1:0];
        sum     = {1'b0, acc_dbl} + {1'b0, i_x};
        sum_red = (sum >= {1'b0, i_m}) ? sum - {1'b0, i_m} : sum;
    end

    always_comb begin
        n_acc  = r_acc;
        n_y    = r_y;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctrl.start && !r_busy) begin
            n_acc  = '0;
            n_y    = i_y;
            n_cnt  = CW'(OPERAND_BITS - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = r_y[OPERAND_BITS-1] ? sum_red[OPERAND_BITS-1:0] : acc_dbl;
            n_y   = {r_y[OPERAND_BITS-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_y   <= n_y;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = r_acc;
endmodule

// ===== rtl/core/modexp_seq.sv =====
// ----------------------------------------------------------------------------
// modexp_seq
// Square-and-multiply sequencer driving the shared modular multiplier.
// ----------------------------------------------------------------------------
module modexp_seq #(
    parameter int unsigned OPERAND_BITS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    modexp_in_if.sink                in_ch,
    modexp_out_if.source             out_ch,
    output modexp_pkg::t_mul_ctrl    o_mul_ctrl,
    input  modexp_pkg::t_mul_stat    i_mul_stat,
    input  logic [OPERAND_BITS-1:0]  i_mul_product,
    output logic [OPERAND_BITS-1:0]  o_mul_x,
    output logic [OPERAND_BITS-1:0]  o_mul_y,
    output logic [OPERAND_BITS-1:0]  o_mul_m
);
    import modexp_pkg::*;

    localparam int unsigned CW = $clog2(OPERAND_BITS);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RBASE = 8'b00000010,
        S_RWAIT = 8'b00000100,
        S_MUL   = 8'b00001000,
        S_MWAIT = 8'b00010000,
        S_SQR   = 8'b00100000,
        S_SWAIT = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state                  r_state, n_state;
    logic [OPERAND_BITS-1:0] r_acc, n_acc, r_sq, n_sq, r_exp, n_exp, r_mod, n_mod;
    logic [CW-1:0]           r_bit, n_bit;
    logic                    r_bad, n_bad;
    logic                    r_ovalid, n_ovalid;
    logic [FIELD_BITS-1:0]   r_res, n_res;
    t_mul_ctrl               mul_ctrl;

    assign in_ch.ready         = (r_state == S_IDLE);
    assign out_ch.valid        = r_ovalid;
    assign out_ch.power_result = r_res;
    assign out_ch.bad_modulus  = r_bad;
    assign o_mul_ctrl          = mul_ctrl;
    assign o_mul_m             = r_mod;
    assign o_mul_y             = r_sq;
    assign o_mul_x             = (r_state inside {S_RBASE, S_RWAIT, S_MUL, S_MWAIT}) ?
                                 r_acc : r_sq;

    always_comb begin
        n_state        = r_state;
        n_acc          = r_acc;
        n_sq           = r_sq;
        n_exp          = r_exp;
        n_mod          = r_mod;
        n_bit          = r_bit;
        n_bad          = r_bad;
        n_res          = r_res;
        n_ovalid       = r_ovalid;
        mul_ctrl.start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_ch.valid) begin
                    n_exp = in_ch.exponent_value[OPERAND_BITS-1:0];
                    n_mod = in_ch.modulus_value[OPERAND_BITS-1:0];
                    // Base starts unreduced; one multiply by (1 mod m) reduces it.
                    n_sq  = in_ch.base_value[OPERAND_BITS-1:0];
                    n_bit = '0;
                    if (in_ch.modulus_value[OPERAND_BITS-1:0] == '0) begin
                        n_bad   = 1'b1;
                        n_res   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_bad   = 1'b0;
                        n_acc   = (in_ch.modulus_value[OPERAND_BITS-1:0] ==
                                   OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);
                        n_state = S_RBASE;
                    end
                end
            end
            // Multiply (1 mod m) as x by the raw base as y: gives base mod m.
            S_RBASE: begin
                mul_ctrl.start = 1'b1;
                n_state = S_RWAIT;
            end
            S_RWAIT: begin
                if (i_mul_stat.done) begin
                    n_sq    = i_mul_product;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_exp[0]) begin
                    mul_ctrl.start = 1'b1;
                    n_state = S_MWAIT;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_MWAIT: begin
                if (i_mul_stat.done) begin
                    n_acc   = i_mul_product;
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                mul_ctrl.start = 1'b1;
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                if (i_mul_stat.done) begin
                    n_sq  = i_mul_product;
                    n_exp = {1'b0, r_exp[OPERAND_BITS-1:1]};
                    n_bit = r_bit + 1'b1;
                    if (r_bit == CW'(OPERAND_BITS - 1)) begin
                        n_res   = FIELD_BITS'(r_acc);
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                if (r_ovalid && out_ch.ready) begin
                    n_ovalid = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_acc <= n_acc;
        r_sq  <= n_sq;
        r_exp <= n_exp;
        r_mod <= n_mod;
        r_bit <= n_bit;
        r_bad <= n_bad;
        r_res <= n_res;
    end
endmodule

// ===== rtl/core/modular_exponentiation_64_unit.sv =====
// Each modular multiply is a start, one bit of y per cycle, then a done pulse;
//   one base reduce, then per exponent bit one square plus a multiply on set bits
//   (a clear bit skips the multiply) lie between accept and result valid.
// Zero modulus: the unit goes straight to S_OUT, which registers result valid.
// Throughput: one item at a time; the single bit-serial multiplier sets the rate.
// Reset (synchronous) clears control.
// ----------------------------------------------------------------------------
// modular_exponentiation_64_unit
// Right-to-left square-and-multiply over a shared iterative modular multiplier.
// ----------------------------------------------------------------------------
module modular_exponentiation_64_unit #(
    parameter int unsigned OPERAND_BITS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    modexp_in_if.sink     in_ch,
    modexp_out_if.source  out_ch
);
    import modexp_pkg::*;

    t_mul_ctrl               mul_ctrl;
    t_mul_stat               mul_stat;
    logic [OPERAND_BITS-1:0] mul_x, mul_y, mul_m, mul_p;

    // Sequencer: scan exponent LSB first, issue squares and multiplies.
    modexp_seq #(.OPERAND_BITS(OPERAND_BITS)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_mul_ctrl   (mul_ctrl),
        .i_mul_stat   (mul_stat),
        .i_mul_product(mul_p),
        .o_mul_x      (mul_x),
        .o_mul_y      (mul_y),
        .o_mul_m      (mul_m)
    );

    // Shared multiplier: one bit of y per cycle, partial sum kept below m.
    modexp_mulmod #(.OPERAND_BITS(OPERAND_BITS)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mul_ctrl),
        .i_x      (mul_x),
        .i_y      (mul_y),
        .i_m      (mul_m),
        .o_stat   (mul_stat),
        .o_product(mul_p)
    );

    // Never accept an item while the multiplier is still working.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> !mul_stat.busy)
        else $error("item accepted while multiplier busy");

    // A done pulse only follows a busy cycle.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> $past(mul_stat.busy))
        else $error("multiplier done without busy");

    // A bad-modulus result always carries zero.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.bad_modulus) |-> (out_ch.power_result == '0))
        else $error("bad modulus with nonzero result");
endmodule

// ===== tb/modular_exponentiation_64_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_exponentiation_64_unit_test
// Drives base/exponent/modulus items into the exponentiation unit and checks
// each result against a square-and-multiply power computed on 128-bit
// products. A directed table covers the zero-modulus error, zero exponents,
// modulus one and full-width operands. Random items follow in four phases of
// sender and receiver idling.
// ----------------------------------------------------------------------------
module modular_exponentiation_64_unit_test;
    import modexp_pkg::*;

    localparam int unsigned OPERAND_BITS = 64;
    localparam t_word       OPERAND_MASK = (OPERAND_BITS >= 64) ? '1 :
                                           ((t_word'(1) << OPERAND_BITS) - 1);
    localparam t_word       ALL_ONES     = '1;
    // Allow many times the slowest full multiply chain.
    localparam longint      CYCLE_LIMIT  = 8_000_000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          ITEMS_PER_PHASE = 20;

    typedef struct {
        t_word power;
        logic  bad;
    } t_power_result;

    typedef struct {
        t_word base;
        t_word expo;
        t_word modulus;
        bit    typed;      // expected result written into the row
        t_word power;
        logic  bad;
    } t_operand_row;

    logic i_clk;
    logic i_rst_n;

    modexp_in_if  in_ch ();
    modexp_out_if out_ch ();

    modular_exponentiation_64_unit #(
        .OPERAND_BITS (OPERAND_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    t_power_result pending_powers[$];
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            items_sent;
    int            bad_modulus_seen = 0;
    int            sender_idle_pct;
    int            receiver_stall_pct;
    longint        cycle_count = 0;

    // Clock: 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Exact product reduction on a 128-bit intermediate.
    function automatic t_word mul_mod(input t_word a, input t_word b, input t_word m);
        logic [127:0] product;
        product = {64'd0, a} * {64'd0, b};
        return t_word'(product % {64'd0, m});
    endfunction

    // Right-to-left square-and-multiply, operands masked to OPERAND_BITS.
    function automatic t_power_result modular_power(input t_word base, input t_word expo,
                                                    input t_word modulus);
        t_power_result r;
        t_word         b;
        t_word         e;
        t_word         m;
        t_word         acc;
        t_word         sq;
        b = base & OPERAND_MASK;
        e = expo & OPERAND_MASK;
        m = modulus & OPERAND_MASK;
        if (m == 0) begin
            r.power = '0;
            r.bad   = 1'b1;
            return r;
        end
        acc = 64'd1 % m;
        sq  = b % m;
        for (int i = 0; i < OPERAND_BITS; i++) begin
            if (e[i]) begin
                acc = mul_mod(acc, sq, m);
            end
            sq = mul_mod(sq, sq, m);
        end
        r.power = acc;
        r.bad   = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Hold each item until accepted; log its expected result on acceptance.
    task automatic send_operands(input t_operand_row row);
        t_power_result expected;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.base_value     <= row.base;
        in_ch.exponent_value <= row.expo;
        in_ch.modulus_value  <= row.modulus;
        do begin
            @(posedge i_clk);
        end while (!(in_ch.valid && in_ch.ready));
        if (row.typed) begin
            expected.power = row.power;
            expected.bad   = row.bad;
        end else begin
            expected = modular_power(row.base, row.expo, row.modulus);
        end
        pending_powers.push_back(expected);
        items_sent++;
    endtask

    function automatic t_word random_word();
        return {$urandom(), $urandom()};
    endfunction

    // Mix of full-width, small and degenerate operands.
    function automatic t_operand_row random_row();
        t_operand_row row;
        int           pick;
        row.typed = 1'b0;
        row.power = '0;
        row.bad   = 1'b0;
        row.base  = random_word();
        row.expo  = random_word();
        pick = $urandom_range(0, 15);
        case (pick)
            0: begin
                row.modulus = '0;
            end
            1: begin
                row.modulus = 64'd1;
            end
            2, 3: begin
                row.modulus = t_word'($urandom_range(2, 1000));
            end
            4: begin
                row.modulus = ALL_ONES - t_word'($urandom_range(0, 3));
            end
            5: begin
                row.expo = t_word'($urandom_range(0, 3));
                row.modulus = random_word();
            end
            6: begin
                row.base = t_word'($urandom_range(0, 2));
                row.modulus = random_word();
            end
            default: begin
                row.modulus = random_word();
            end
        endcase
        return row;
    endfunction

    // Receiver back-pressure, redrawn each cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_power_result expected;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (pending_powers.size() == 0) begin
                report_mismatch($sformatf("unexpected result power=%h bad=%b",
                                          out_ch.power_result, out_ch.bad_modulus));
            end else begin
                expected = pending_powers.pop_front();
                if (out_ch.power_result !== expected.power) begin
                    report_mismatch($sformatf("power_result got %h want %h",
                                              out_ch.power_result, expected.power));
                end
                if (out_ch.bad_modulus !== expected.bad) begin
                    report_mismatch($sformatf("bad_modulus got %b want %b",
                                              out_ch.bad_modulus, expected.bad));
                end
                if (expected.bad) begin
                    bad_modulus_seen++;
                end
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_powers.size());
            $display("modular_exponentiation_64_unit_test failed");
            $finish;
        end
    end

    task automatic wait_for_drain();
        while (pending_powers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        t_operand_row directed_rows[$];
        items_sent         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.base_value     = '0;
        in_ch.exponent_value = '0;
        in_ch.modulus_value  = '0;

        //                base              exponent          modulus          typed power  bad
        directed_rows = '{
            '{64'd0,           64'd0,            64'd0,           1'b1, 64'd0,  1'b1},
            '{ALL_ONES,        ALL_ONES,         64'd0,           1'b1, 64'd0,  1'b1},
            '{64'd0,           64'd0,            64'd7,           1'b1, 64'd1,  1'b0},
            '{64'd0,           64'd0,            64'd1,           1'b1, 64'd0,  1'b0},
            '{ALL_ONES,        ALL_ONES,         64'd1,           1'b1, 64'd0,  1'b0},
            '{64'd5,           64'd0,            ALL_ONES,        1'b1, 64'd1,  1'b0},
            '{64'd0,           64'd5,            64'd13,          1'b1, 64'd0,  1'b0},
            '{ALL_ONES,        64'd1,            ALL_ONES,        1'b1, 64'd0,  1'b0},
            '{64'd100,         64'd1,            64'd7,           1'b1, 64'd2,  1'b0},
            '{64'd2,           64'd10,           64'd1000,        1'b1, 64'd24, 1'b0},
            '{64'd2,           64'd63,           ALL_ONES,        1'b1,
              64'h8000_0000_0000_0000, 1'b0},
            '{64'd1,           ALL_ONES,         ALL_ONES,        1'b1, 64'd1,  1'b0},
            '{ALL_ONES,        ALL_ONES,         ALL_ONES - 1,    1'b0, 64'd0,  1'b0},
            '{64'd3,           ALL_ONES,         ALL_ONES,        1'b0, 64'd0,  1'b0},
            '{ALL_ONES - 1,    64'd2,            ALL_ONES,        1'b0, 64'd0,  1'b0},
            '{64'd3,           64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFC5,
              1'b0, 64'd0, 1'b0},
            '{64'd123456789,   64'd987654321,    64'd1000000007,  1'b0, 64'd0,  1'b0},
            '{64'hDEAD_BEEF_0123_4567, 64'h5555_5555_5555_5555,
              64'h8000_0000_0000_0001, 1'b0, 64'd0, 1'b0},
            '{64'h1234_5678_9ABC_DEF0, 64'hAAAA_AAAA_AAAA_AAAA,
              64'h0000_0001_0000_0000, 1'b0, 64'd0, 1'b0},
            '{64'hFFFF_FFFF,   64'd65537,        64'hFFFF_FFFF_0000_0001, 1'b0, 64'd0, 1'b0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, no idling.
        foreach (directed_rows[i]) begin
            send_operands(directed_rows[i]);
        end

        // Random items across idling phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
                default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
            endcase
            if (phase == 2) begin
                // Hold the sender until the unit has delivered everything.
                in_ch.valid <= 1'b0;
                wait_for_drain();
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_operands(random_row());
            end
        end
        in_ch.valid <= 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d items (%0d directed), %0d results checked, %0d zero-modulus cases.",
                 items_sent, directed_rows.size(), results_seen, bad_modulus_seen);
        $display("Idling phases: none, sender 68%%, receiver 68%%, both 28%%; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0 && pending_powers.size() == 0) begin
            $display("modular_exponentiation_64_unit_test passed");
        end else begin
            $display("modular_exponentiation_64_unit_test failed");
        end
        $finish;
    end

endmodule
